// ===== rtl/cwga_pkg.sv =====
// shared types and constants for the 3x3 weight gradient accumulator
// no dependencies
`default_nettype none

package cwga_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int ACC_WIDTH  = 48;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int SUM_WIDTH  = ACC_WIDTH + 1;
  localparam int NUM_TAPS   = 9;
  localparam int TAP_DIM    = 3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [ACC_WIDTH-1:0]  acc_t;
  typedef logic signed [SUM_WIDTH-1:0]  sum_t;
  typedef logic        [1:0]            tap_idx_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  localparam tap_idx_t TAP_LAST = tap_idx_t'(TAP_DIM - 1);

endpackage

`default_nettype wire

// ===== rtl/conv3x3_weight_gradient_accumulator_unit.sv =====
// top level: 3x3 weight gradient accumulator with nine saturating taps
// depends on cwga_pkg
// the first result is valid once the last word has passed the input and product stages
// throughput: one input word per cycle unless stalled; the nine results drain one per cycle
// while result_ready is high, from a snapshot shift register, as new words keep accumulating
// a last word stalls the input only while the previous nine results still drain
// reset (rst, synchronous) clears accumulators, pipeline valids and output state
`default_nettype none

module conv3x3_weight_gradient_accumulator_unit (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  output logic                   item_ready,
  input  wire cwga_pkg::data_t   grad_value,
  input  wire cwga_pkg::data_t   act_r0s0,
  input  wire cwga_pkg::data_t   act_r0s1,
  input  wire cwga_pkg::data_t   act_r0s2,
  input  wire cwga_pkg::data_t   act_r1s0,
  input  wire cwga_pkg::data_t   act_r1s1,
  input  wire cwga_pkg::data_t   act_r1s2,
  input  wire cwga_pkg::data_t   act_r2s0,
  input  wire cwga_pkg::data_t   act_r2s1,
  input  wire cwga_pkg::data_t   act_r2s2,
  input  wire                    last_pixel,
  output logic                   result_valid,
  input  wire                    result_ready,
  output cwga_pkg::tap_idx_t     tap_row,
  output cwga_pkg::tap_idx_t     tap_col,
  output cwga_pkg::acc_t         grad_sum,
  output logic                   last_tap
);

  // input stage
  logic            s1_valid;
  logic            s1_last;
  cwga_pkg::data_t s1_grad;
  cwga_pkg::data_t s1_act [cwga_pkg::NUM_TAPS];

  // product stage
  logic            s2_valid;
  logic            s2_last;
  cwga_pkg::prod_t s2_prod [cwga_pkg::NUM_TAPS];

  cwga_pkg::acc_t  acc     [cwga_pkg::NUM_TAPS];
  cwga_pkg::acc_t  acc_sat [cwga_pkg::NUM_TAPS];
  cwga_pkg::acc_t  snap    [cwga_pkg::NUM_TAPS];

  logic buf_free;
  logic stall;
  logic adv;
  logic s2_fire;
  logic out_fire;

  assign out_fire = result_valid && result_ready;
  assign last_tap = (tap_row == cwga_pkg::TAP_LAST) && (tap_col == cwga_pkg::TAP_LAST);
  assign buf_free = !result_valid || (out_fire && last_tap);
  assign stall    = s2_valid && s2_last && !buf_free;
  assign adv      = !stall;
  assign item_ready = adv;
  assign s2_fire  = s2_valid && adv;
  assign grad_sum = snap[0];

  // saturating add per tap
  always_comb begin
    cwga_pkg::sum_t sum;
    for (int t = 0; t < cwga_pkg::NUM_TAPS; t++) begin
      sum = cwga_pkg::sum_t'(acc[t]) + cwga_pkg::sum_t'(s2_prod[t]);
      if (sum[cwga_pkg::SUM_WIDTH-1] != sum[cwga_pkg::SUM_WIDTH-2]) begin
        acc_sat[t] = sum[cwga_pkg::SUM_WIDTH-1] ? cwga_pkg::ACC_MIN : cwga_pkg::ACC_MAX;
      end else begin
        acc_sat[t] = sum[cwga_pkg::ACC_WIDTH-1:0];
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_grad   <= grad_value;
      s1_last   <= last_pixel;
      s1_act[0] <= act_r0s0;
      s1_act[1] <= act_r0s1;
      s1_act[2] <= act_r0s2;
      s1_act[3] <= act_r1s0;
      s1_act[4] <= act_r1s1;
      s1_act[5] <= act_r1s2;
      s1_act[6] <= act_r2s0;
      s1_act[7] <= act_r2s1;
      s1_act[8] <= act_r2s2;
      s2_last   <= s1_last;
      for (int t = 0; t < cwga_pkg::NUM_TAPS; t++) begin
        s2_prod[t] <= cwga_pkg::prod_t'(s1_grad) * cwga_pkg::prod_t'(s1_act[t]);
      end
    end
  end

  // snapshot shift register
  always_ff @(posedge clk) begin
    if (s2_fire && s2_last) begin
      for (int t = 0; t < cwga_pkg::NUM_TAPS; t++) begin
        snap[t] <= acc_sat[t];
      end
    end else if (out_fire) begin
      for (int t = 0; t < cwga_pkg::NUM_TAPS - 1; t++) begin
        snap[t] <= snap[t+1];
      end
    end
  end

  // control and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
      tap_row      <= '0;
      tap_col      <= '0;
      for (int t = 0; t < cwga_pkg::NUM_TAPS; t++) begin
        acc[t] <= '0;
      end
    end else begin
      if (adv) begin
        s1_valid <= item_valid;
        s2_valid <= s1_valid;
      end
      if (s2_fire) begin
        for (int t = 0; t < cwga_pkg::NUM_TAPS; t++) begin
          acc[t] <= s2_last ? '0 : acc_sat[t];
        end
      end
      if (s2_fire && s2_last) begin
        result_valid <= 1'b1;
        tap_row      <= '0;
        tap_col      <= '0;
      end else if (out_fire) begin
        if (last_tap) begin
          result_valid <= 1'b0;
          tap_row      <= '0;
          tap_col      <= '0;
        end else if (tap_col == cwga_pkg::TAP_LAST) begin
          tap_col <= '0;
          tap_row <= tap_row + 2'd1;
        end else begin
          tap_col <= tap_col + 2'd1;
        end
      end
    end
  end

  // input stalls only behind a last word waiting for the drain to finish
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (s2_valid && s2_last && result_valid))
    else $error("input stalled without a pending snapshot");

  // a drain in progress keeps going until the ninth tap
  a_drain_continues: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !last_tap) |=> result_valid)
    else $error("result drain stopped before the ninth tap");

  // a last word reaching the accumulators starts a fresh drain at tap zero
  a_snapshot_start: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && s2_last) |=> (result_valid && tap_row == '0 && tap_col == '0))
    else $error("snapshot did not start a new drain");

  // tap coordinates stay on the 3x3 kernel
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (tap_row != 2'd3 && tap_col != 2'd3))
    else $error("tap coordinate out of kernel");

endmodule

`default_nettype wire
